>>> hdl/bma_pkg.sv
// shared types and constants for the boxcar moving average
// no dependencies; imported by every module of the block
package bma_pkg;

    // window length and field widths
    localparam int WINDOW   = 100;
    localparam int SAMPLE_W = 12;
    localparam int PTR_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W    = $clog2(WINDOW + 1);
    localparam int SUM_W    = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);
    localparam int STEP_W   = $clog2(SUM_W + 1);

    // one division job handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
    } bma_job_t;

    // queue status seen by the front and back
    typedef struct packed {
        logic empty;
        logic full;
    } bma_q_status_t;

    typedef enum logic {
        FRONT_IDLE,
        FRONT_UPDATE
    } bma_front_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } bma_div_state_t;

endpackage

>>> hdl/bma_front.sv
// front end: takes samples, keeps the circular window and running sum
// depends on bma_pkg; feeds division jobs into bma_queue
module bma_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [bma_pkg::SAMPLE_W-1:0]  sample,
    output logic                          full,
    input  bma_pkg::bma_q_status_t        q_status,
    output logic                          job_push,
    output bma_pkg::bma_job_t             job
);
    import bma_pkg::*;

    bma_front_state_t      state_reg, state_next;
    logic [SAMPLE_W-1:0]   window_mem [WINDOW];
    logic [SAMPLE_W-1:0]   sample_reg;
    logic [SAMPLE_W-1:0]   old_reg;
    logic [PTR_W-1:0]      wptr_reg, wptr_next;
    logic [CNT_W-1:0]      fill_reg, fill_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic                  accept;
    logic                  win_full;

    assign full     = (state_reg != FRONT_IDLE) || q_status.full;
    assign accept   = push && !full;
    assign win_full = (fill_reg == CNT_W'(WINDOW));

    // window memory: read the slot about to be overwritten, write it next cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample;
            old_reg    <= window_mem[wptr_reg];
        end
        if (state_reg == FRONT_UPDATE)
        begin
            window_mem[wptr_reg] <= sample_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FRONT_IDLE;
            wptr_reg  <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wptr_reg  <= wptr_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
        end
    end

    // next state, sum update and job push
    always_comb
    begin
        state_next = state_reg;
        wptr_next  = wptr_reg;
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        job_push   = 1'b0;
        unique case (state_reg)
            FRONT_IDLE:
            begin
                if (accept)
                begin
                    state_next = FRONT_UPDATE;
                end
            end
            FRONT_UPDATE:
            begin
                sum_next = sum_reg - (win_full ? SUM_W'(old_reg) : SUM_W'(0))
                         + SUM_W'(sample_reg);
                if (!win_full)
                begin
                    fill_next = fill_reg + CNT_W'(1);
                end
                if (wptr_reg == PTR_W'(WINDOW - 1))
                begin
                    wptr_next = '0;
                end
                else
                begin
                    wptr_next = wptr_reg + PTR_W'(1);
                end
                job_push   = 1'b1;
                state_next = FRONT_IDLE;
            end
            default:
            begin
                state_next = FRONT_IDLE;
            end
        endcase
        job.sum   = sum_next;
        job.count = fill_next;
    end

endmodule

>>> hdl/bma_queue.sv
// two-entry job queue between front and back
// depends on bma_pkg
module bma_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  bma_pkg::bma_job_t       job_in,
    input  logic                    pop,
    output bma_pkg::bma_job_t       job_out,
    output bma_pkg::bma_q_status_t  status
);
    import bma_pkg::*;

    bma_job_t     entry_reg [2];
    logic         rptr_reg, rptr_next;
    logic         wptr_reg, wptr_next;
    logic [1:0]   count_reg, count_next;
    logic         do_push;
    logic         do_pop;

    assign status.empty = (count_reg == 2'd0);
    assign status.full  = (count_reg == 2'd2);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign job_out      = entry_reg[rptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wptr_reg] <= job_in;
        end
    end

    // pointers and count
    always_comb
    begin
        rptr_next  = rptr_reg ^ do_pop;
        wptr_next  = wptr_reg ^ do_push;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg  <= 1'b0;
            wptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            rptr_reg  <= rptr_next;
            wptr_reg  <= wptr_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> hdl/bma_divider.sv
// back end: restoring divider, one quotient bit per cycle, and result register
// depends on bma_pkg; takes jobs from bma_queue
module bma_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bma_pkg::bma_q_status_t        q_status,
    input  bma_pkg::bma_job_t             job,
    output logic                          job_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [bma_pkg::SAMPLE_W-1:0]  average
);
    import bma_pkg::*;

    bma_div_state_t        state_reg, state_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [CNT_W-1:0]      div_reg, div_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0]   average_reg, average_next;
    logic [CNT_W:0]        rem_shift;
    logic [CNT_W:0]        rem_diff;
    logic                  out_free;

    assign empty    = !out_valid_reg;
    assign average  = average_reg;
    assign out_free = !out_valid_reg || pop;

    // one restoring step
    assign rem_shift = {rem_reg, quo_reg[SUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= DIV_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        average_reg <= average_next;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        div_next       = div_reg;
        average_next   = average_reg;
        out_valid_next = out_valid_reg && !pop;
        job_pop        = 1'b0;
        unique case (state_reg)
            DIV_IDLE:
            begin
                if (!q_status.empty)
                begin
                    job_pop    = 1'b1;
                    quo_next   = job.sum;
                    div_next   = job.count;
                    rem_next   = '0;
                    step_next  = STEP_W'(SUM_W);
                    state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (!rem_diff[CNT_W])
                begin
                    rem_next = rem_diff[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[CNT_W-1:0];
                    quo_next = {quo_reg[SUM_W-2:0], 1'b0};
                end
                step_next = step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    state_next = DIV_DONE;
                end
            end
            DIV_DONE:
            begin
                // hand the beat to the result register once it is free
                if (out_free)
                begin
                    average_next   = quo_reg[SAMPLE_W-1:0];
                    out_valid_next = 1'b1;
                    state_next     = DIV_IDLE;
                end
            end
            default:
            begin
                state_next = DIV_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/boxcar_moving_average.sv
// boxcar moving average over a circular window of 100 samples
// a sample goes through the front, the job queue and the divider to the result register
// the bit-serial 19-step divider takes a new job only after its last result is handed on
// the front takes a new sample only when idle and while the job queue has room
// reset clears pointer, fill count, running sum and all queues; window memory is not cleared
// depends on bma_pkg, bma_front, bma_queue, bma_divider
module boxcar_moving_average (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bma_pkg::SAMPLE_W-1:0]  sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [bma_pkg::SAMPLE_W-1:0]  average
);
    import bma_pkg::*;

    bma_job_t       front_job;
    bma_job_t       queue_job;
    bma_q_status_t  q_status;
    logic           job_push;
    logic           job_pop;

    // sample intake and running sum
    bma_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .sample   (sample),
        .full     (full),
        .q_status (q_status),
        .job_push (job_push),
        .job      (front_job)
    );

    // decoupling queue
    bma_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (front_job),
        .pop     (job_pop),
        .job_out (queue_job),
        .status  (q_status)
    );

    // division and result register
    bma_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .job      (queue_job),
        .job_pop  (job_pop),
        .pop      (pop),
        .empty    (empty),
        .average  (average)
    );

endmodule

>>> dv/boxcar_moving_average_tb.sv
// self-checking testbench for the boxcar moving average block
// depends on bma_pkg and boxcar_moving_average; a local predictor tracks
// the window, fill count and running sum and checks every average beat
module boxcar_moving_average_tb;

    import bma_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int CALM_FIRST = 4000;
    localparam int CALM_LAST = 8000;
    localparam int TOTAL_ITEMS = 1000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    logic [SAMPLE_W-1:0] average;

    // stimulus and expectation stores
    logic [SAMPLE_W-1:0] pending_samples[$];
    logic [SAMPLE_W-1:0] expected_averages[$];

    // predictor state
    logic [SAMPLE_W-1:0] window_mem [WINDOW];
    int unsigned         wr_slot = 0;
    logic [CNT_W-1:0]    held_count = '0;
    logic [SUM_W-1:0]    running_total = '0;

    int unsigned cycle_count = 0;
    int unsigned stall_cycles = 0;
    int unsigned error_count = 0;

    boxcar_moving_average u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .sample  (sample),
        .empty   (empty),
        .pop     (pop),
        .average (average)
    );

    // clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // add one sample to the window and queue the mean it gives
    function automatic void add_to_window(input logic [SAMPLE_W-1:0] s);
        if (held_count == CNT_W'(WINDOW))
            running_total = running_total - SUM_W'(window_mem[wr_slot]);
        else
            held_count = held_count + 1'b1;
        running_total = running_total + SUM_W'(s);
        window_mem[wr_slot] = s;
        wr_slot = (wr_slot == WINDOW - 1) ? 0 : wr_slot + 1;
        expected_averages.push_back(SAMPLE_W'(running_total / held_count));
    endfunction

    // random idling, switched off for one long stretch of cycles
    function automatic bit take_break();
        if (cycle_count >= CALM_FIRST && cycle_count <= CALM_LAST)
            return 1'b0;
        return $urandom_range(99) < 35;
    endfunction

    // pick a sample at or next to the ends or the midpoint of the range
    function automatic logic [SAMPLE_W-1:0] corner_sample();
        case ($urandom_range(5))
            0: return '0;
            1: return SAMPLE_W'(1);
            2: return SAMPLE_MAX - 1'b1;
            3: return SAMPLE_MAX;
            4: return SAMPLE_W'(1 << (SAMPLE_W - 1));
            default: return SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1);
        endcase
    endfunction

    // cycle counter and stall watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if ((push && !full) || (pop && !empty))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("boxcar_moving_average_tb: FAIL");
            $finish;
        end
    end

    // sample driver
    always @(posedge clk)
    begin : drive_samples
        bit accepted;
        accepted = push && !full;
        if (accepted)
        begin
            add_to_window(sample);
            void'(pending_samples.pop_front());
        end
        if (!rst_n)
            push <= 1'b0;
        else if (push && !accepted)
            push <= 1'b1;
        else if (pending_samples.size() != 0 && !take_break())
        begin
            push <= 1'b1;
            sample <= pending_samples[0];
        end
        else
            push <= 1'b0;
    end

    // average monitor
    always @(posedge clk)
    begin : check_averages
        logic [SAMPLE_W-1:0] want;
        if (pop && !empty)
        begin
            if (expected_averages.size() == 0)
            begin
                $error("average beat with nothing expected: actual %0d", average);
                error_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (average !== want)
                begin
                    $error("average mismatch: expected %0d, actual %0d", want, average);
                    error_count++;
                end
            end
        end
        pop <= rst_n && !take_break();
    end

    // stimulus, reset and end of run
    initial
    begin : stimulus
        int seg_len;
        int seg_kind;

        // directed: extremes, bit patterns, warm-up divisors
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back('0);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(SAMPLE_MAX);
        pending_samples.push_back(SAMPLE_W'(12'hAAA));
        pending_samples.push_back(SAMPLE_W'(12'h555));
        pending_samples.push_back(SAMPLE_W'(1));
        pending_samples.push_back(SAMPLE_MAX - 1'b1);
        pending_samples.push_back(SAMPLE_W'(1 << (SAMPLE_W - 1)));
        pending_samples.push_back(SAMPLE_W'((1 << (SAMPLE_W - 1)) - 1));
        pending_samples.push_back('0);
        pending_samples.push_back('0);
        pending_samples.push_back(SAMPLE_W'(7));
        pending_samples.push_back(SAMPLE_MAX);

        // random segments; constant runs at least as long as the window hit the
        // full-window extremes and force many pointer wraps
        while (pending_samples.size() < TOTAL_ITEMS)
        begin
            seg_kind = $urandom_range(9);
            if (seg_kind >= 6 && seg_kind <= 7)
                seg_len = $urandom_range(WINDOW + 20, WINDOW);
            else
                seg_len = $urandom_range(60, 10);
            repeat (seg_len)
            begin
                case (seg_kind)
                    6: pending_samples.push_back(SAMPLE_MAX);
                    7: pending_samples.push_back('0);
                    8: pending_samples.push_back(corner_sample());
                    9: pending_samples.push_back(SAMPLE_W'($urandom_range(15)));
                    default: pending_samples.push_back(SAMPLE_W'($urandom()));
                endcase
            end
        end

        // reset
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all samples to go in and all averages to come out
        while (pending_samples.size() != 0 || push || expected_averages.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_averages.size() == 0)
            $display("boxcar_moving_average_tb: PASS");
        else
            $display("boxcar_moving_average_tb: FAIL");
        $finish;
    end

endmodule
